// File: hw/rtl/dws_pkg.sv
`default_nettype none

package dws_pkg;

  // Field widths
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CMD_W       = 3;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned POS_W       = 5;
  localparam int unsigned OCC_W       = 5;
  localparam int unsigned OUT_TDATA_W = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEARCH     = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [OCC_W-1:0]    occupancy;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/deque_with_search_core.sv
`default_nettype none

// Bounded double-ended queue of DEPTH signed 32-bit values held in a ring
// buffer in one synchronous single-read-port memory, with a linear search.
// in_tuser carries the command (push front, push back, pop front, pop back,
// search) and in_tdata the value or search key; every command returns one
// item with a status in out_tuser and the match position and occupancy in
// out_tdata. Pushes, pops, unused codes and a search on an empty queue are
// finished in the cycle they are taken. A search walks the entries from
// the front, up to and including the first match, or all of them on a miss:
// the walk reads one entry per cycle through the single memory read port,
// and the next item is taken once it ends. A finished result sits in an
// output register; if that register is still full the result is parked,
// the input is held off, and the result moves over once the output frees.
// Pop on empty reports status 1, push on full reports status 2 and drops the
// value; a search miss reports status 3 with position 0.

module deque_with_search_core #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  // in_tdata: [31:0] value
  input  wire  [dws_pkg::VALUE_W-1:0]         in_tdata,
  // in_tuser: [2:0] cmd
  input  wire  [dws_pkg::CMD_W-1:0]           in_tuser,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  // out_tdata: [4:0] position, [9:5] occupancy, [15:10] zero
  output logic [dws_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // out_tuser: [1:0] status
  output logic [dws_pkg::STATUS_W-1:0]        out_tuser,
  output logic                                out_tvalid,
  input  wire                                 out_tready
);

  import dws_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  // Ring index helpers
  function automatic logic [AW-1:0] slot_inc(input logic [AW-1:0] s);
    slot_inc = (s == AW'(DEPTH - 1)) ? '0 : s + AW'(1);
  endfunction

  function automatic logic [AW-1:0] slot_dec(input logic [AW-1:0] s);
    slot_dec = (s == '0) ? AW'(DEPTH - 1) : s - AW'(1);
  endfunction

  logic [VALUE_W-1:0] entry_mem [DEPTH];
  logic [VALUE_W-1:0] rdata_r;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [AW-1:0]      mem_raddr;

  logic [1:0]         state_r, state_nxt;
  logic [AW-1:0]      front_r, front_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [VALUE_W-1:0] key_r, key_nxt;
  logic [AW-1:0]      slot_r, slot_nxt;
  logic [CW-1:0]      off_r, off_nxt;
  res_t               res_r, res_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]    out_user_r, out_user_nxt;

  logic               accept;
  logic               out_free;
  logic               finish;
  res_t               fin_res;
  logic               full;
  logic               empty;
  logic [SW-1:0]      back_sum;
  logic [AW-1:0]      back_slot;
  logic [CW-1:0]      off_inc;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign full       = (count_r == CW'(DEPTH));
  assign empty      = (count_r == '0);
  assign off_inc    = off_r + CW'(1);

  // Slot just past the back entry: front + count, wrapped once
  assign back_sum  = SW'(front_r) + SW'(count_r);
  assign back_slot = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Command decode, search walk and result hand-off
  always_comb begin
    state_nxt     = state_r;
    front_nxt     = front_r;
    count_nxt     = count_r;
    key_nxt       = key_r;
    slot_nxt      = slot_r;
    off_nxt       = off_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    mem_we        = 1'b0;
    mem_waddr     = front_r;
    mem_raddr     = front_r;
    finish        = 1'b0;
    fin_res       = '0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          fin_res.status = ST_OK;
          finish         = 1'b1;
          case (in_tuser)
            CMD_PUSH_FRONT: begin
              if (full) begin
                fin_res.status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = slot_dec(front_r);
                front_nxt = slot_dec(front_r);
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_PUSH_BACK: begin
              if (full) begin
                fin_res.status = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = back_slot;
                count_nxt = count_r + CW'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (empty) begin
                fin_res.status = ST_EMPTY;
              end else begin
                front_nxt = slot_inc(front_r);
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_POP_BACK: begin
              if (empty) begin
                fin_res.status = ST_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
              end
            end
            CMD_SEARCH: begin
              if (empty) begin
                fin_res.status = ST_NOT_FOUND;
              end else begin
                // front entry is being read this cycle
                finish    = 1'b0;
                key_nxt   = in_tdata;
                slot_nxt  = front_r;
                off_nxt   = '0;
                state_nxt = S_SRCH;
              end
            end
            default: begin
              fin_res.status = ST_OK;
            end
          endcase
          fin_res.occupancy = OCC_W'(count_nxt);
        end
      end
      S_SRCH: begin
        // compare the entry read last cycle, fetch the next one
        mem_raddr         = slot_inc(slot_r);
        slot_nxt          = slot_inc(slot_r);
        fin_res.occupancy = OCC_W'(count_r);
        if (rdata_r == key_r) begin
          finish           = 1'b1;
          fin_res.status   = ST_OK;
          fin_res.position = POS_W'(off_inc);
        end else if (off_inc == count_r) begin
          finish         = 1'b1;
          fin_res.status = ST_NOT_FOUND;
        end else begin
          off_nxt = off_inc;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_TDATA_W'({res_r.occupancy, res_r.position});
          out_user_nxt  = res_r.status;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Deliver a finished result, or park it while the output is busy
    if (finish) begin
      if (out_free) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = OUT_TDATA_W'({fin_res.occupancy, fin_res.position});
        out_user_nxt  = fin_res.status;
        state_nxt     = S_IDLE;
      end else begin
        res_nxt   = fin_res;
        state_nxt = S_HOLD;
      end
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[mem_waddr] <= in_tdata;
    end
    rdata_r <= entry_mem[mem_raddr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    slot_r     <= slot_nxt;
    off_r      <= off_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

`default_nettype wire

// File: tb/tb.sv
`default_nettype none

module tb;
  import dws_pkg::*;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned HOLD_CYCLES    = 250;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES    = 2 * DEPTH + 8;
  localparam int unsigned IDLE_PCT       = 8;

  // Command codes the block leaves unused
  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic [VALUE_W-1:0]     in_tdata   = '0;
  logic [CMD_W-1:0]       in_tuser   = '0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]    out_tuser;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;

  deque_with_search_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // Free-running clock, period 20
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the deque
  logic [VALUE_W-1:0] dq_store [DEPTH];
  logic [3:0]         dq_front = '0;
  logic [OCC_W-1:0]   dq_count = '0;

  res_t pending_results [$];

  bit          in_idle_en  = 1'b1;
  bit          out_idle_en = 1'b1;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned idle_cycles = 0;

  int unsigned fail_count = 0;
  int unsigned n_items_in = 0;
  int unsigned n_results  = 0;
  int unsigned n_hits     = 0;
  int unsigned n_misses   = 0;
  int unsigned n_full     = 0;
  int unsigned n_empty    = 0;

  // Apply one command to the shadow deque and return the result it yields
  function automatic res_t apply_deque_cmd(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] val);
    res_t        r;
    int unsigned k;
    r.status   = ST_OK;
    r.position = '0;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (dq_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          dq_front           = dq_front - 4'd1;
          dq_store[dq_front] = val;
          dq_count           = dq_count + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (dq_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          dq_store[4'(dq_front + dq_count)] = val;
          dq_count = dq_count + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (dq_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          dq_front = dq_front + 4'd1;
          dq_count = dq_count - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (dq_count == 0) r.status = ST_EMPTY;
        else dq_count = dq_count - 1'b1;
      end
      CMD_SEARCH: begin
        // first match from the front wins
        r.status = ST_NOT_FOUND;
        for (k = 0; k < dq_count; k++) begin
          if (r.status == ST_NOT_FOUND && dq_store[4'(dq_front + k)] == val) begin
            r.status   = ST_OK;
            r.position = POS_W'(k + 1);
          end
        end
      end
      default: ;
    endcase
    r.occupancy = dq_count;
    return r;
  endfunction

  // Mix of extremes, a small pool that forces duplicates, and full-range values
  function automatic logic [VALUE_W-1:0] pick_value();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 15) begin
      case ($urandom_range(4))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    if (roll < 40) return 32'($urandom_range(7));
    return $urandom;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endtask

  // Offer one item and hold it until the block takes it
  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] val);
    @(negedge clk);
    while (in_idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), apply_deque_cmd(cmd, val));
    n_items_in++;
  endtask

  // Drop valid and wait until every result has come back
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Choose a command; bias 0 grows the deque, 1 shrinks it, 2 keeps it level
  task automatic pick_random_item(input int unsigned bias, output logic [CMD_W-1:0] cmd,
                                  output logic [VALUE_W-1:0] val);
    int unsigned push_lim [3] = '{70, 15, 35};
    int unsigned pop_lim  [3] = '{85, 70, 65};
    int unsigned roll;
    val  = pick_value();
    roll = $urandom_range(99);
    if (roll < 3) begin
      cmd = CMD_RSVD_5 + CMD_W'($urandom_range(2));
    end else begin
      roll = $urandom_range(99);
      if (roll < push_lim[bias]) begin
        cmd = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      end else if (roll < pop_lim[bias]) begin
        cmd = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
      end else begin
        cmd = CMD_SEARCH;
        // mostly search for something that is held
        if (dq_count != 0 && $urandom_range(99) < 65)
          val = dq_store[4'(dq_front + $urandom_range(dq_count - 1))];
      end
    end
  endtask

  task automatic test_empty_queue();
    send_item(CMD_POP_FRONT, 32'h0);
    send_item(CMD_POP_BACK, $urandom);
    send_item(CMD_SEARCH, 32'h0);
    send_item(CMD_RSVD_7, 32'hFFFF_FFFF);
    send_item(CMD_RSVD_5, $urandom);
    wait_drained();
  endtask

  task automatic test_extremes_and_full();
    int unsigned k;
    send_item(CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_item(CMD_PUSH_FRONT, 32'h8000_0000);
    send_item(CMD_PUSH_BACK, 32'h0000_0000);
    send_item(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_item(CMD_SEARCH, 32'h0000_0000);
    send_item(CMD_SEARCH, 32'h8000_0000);
    send_item(CMD_SEARCH, 32'h0001_2345);
    // fill to the top, wrapping the ring from both ends with repeated values
    for (k = 0; k < 12; k++) begin
      if (k % 2 == 0) send_item(CMD_PUSH_FRONT, 32'h100 + k % 3);
      else send_item(CMD_PUSH_BACK, 32'h200 + k);
    end
    send_item(CMD_PUSH_FRONT, 32'h1);
    send_item(CMD_PUSH_BACK, 32'h1);
    send_item(CMD_SEARCH, 32'h20B);
    send_item(CMD_SEARCH, 32'h100);
    wait_drained();
  endtask

  task automatic test_random_mix(input int unsigned count);
    int unsigned      i;
    int unsigned      bias;
    logic [CMD_W-1:0] cmd;
    logic [VALUE_W-1:0] val;
    bias = 2;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) bias = $urandom_range(2);
      pick_random_item(bias, cmd, val);
      send_item(cmd, val);
    end
    wait_drained();
  endtask

  task automatic test_back_to_back(input int unsigned count);
    in_idle_en  = 1'b0;
    out_idle_en = 1'b0;
    test_random_mix(count);
    in_idle_en  = 1'b1;
    out_idle_en = 1'b1;
  endtask

  // Receiver holds off while items keep coming, so the block backs up
  task automatic test_output_stall(input int unsigned count);
    hold_req++;
    test_random_mix(count);
  endtask

  // Receiver: random stalls, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (out_idle_en) begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      case (out_tuser)
        ST_FULL:      n_full++;
        ST_EMPTY:     n_empty++;
        ST_NOT_FOUND: n_misses++;
        default:      if (out_tdata[POS_W-1:0] != 0) n_hits++;
      endcase
      if (pending_results.size() == 0) begin
        note_failure($sformatf("result with nothing pending: status %0d tdata 0x%04h",
                               out_tuser, out_tdata));
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_tuser != want.status)
          note_failure($sformatf("status: expected %0d, got %0d", want.status, out_tuser));
        if (out_tdata[POS_W-1:0] != want.position)
          note_failure($sformatf("position: expected %0d, got %0d",
                                 want.position, out_tdata[POS_W-1:0]));
        if (out_tdata[POS_W +: OCC_W] != want.occupancy)
          note_failure($sformatf("occupancy: expected %0d, got %0d",
                                 want.occupancy, out_tdata[POS_W +: OCC_W]));
        if (out_tdata[OUT_TDATA_W-1:POS_W+OCC_W] != '0)
          note_failure($sformatf("padding bits: expected 0, got 0x%0h",
                                 out_tdata[OUT_TDATA_W-1:POS_W+OCC_W]));
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("** deque_with_search_core: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queue();
    test_extremes_and_full();
    test_random_mix(1340);
    test_back_to_back(200);
    test_output_stall(80);

    // settle: catch any stray result after the last expected one
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d commands, checked %0d results", n_items_in, n_results);
    $display("search hits %0d, misses %0d, pushes on full %0d, pops on empty %0d",
             n_hits, n_misses, n_full, n_empty);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("** deque_with_search_core: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_count, pending_results.size());
      $display("** deque_with_search_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
